// ===== hw/rtl/iaf_pkg.sv =====
// shared types, constants and the digit glyph table for the integer to ascii formatter
// no dependencies; imported by iaf_dabble_step, iaf_seq and integer_to_ascii_formatter
package iaf_pkg;

  localparam int ValueW    = 32;
  localparam int CharW     = 8;
  localparam int DigitW    = 4;
  localparam int NumDigits = 11;
  localparam int DigitsW   = NumDigits * DigitW;
  localparam int NdigW     = $clog2(NumDigits + 1);
  localparam int CntW      = $clog2(ValueW);

  typedef enum logic [1:0] {
    CMD_UDEC = 2'd0,
    CMD_SDEC = 2'd1,
    CMD_OCT  = 2'd2,
    CMD_HEX  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_MINUS,
    ST_ZERO,
    ST_X,
    ST_DIGIT
  } state_e;

  localparam logic [CharW-1:0] AsciiMinus = 8'h2D;
  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiX     = 8'h78;

  // upper-case hex glyphs, index is the digit value
  localparam logic [CharW-1:0] Glyphs [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // one character handed from the sequencer to the output register
  typedef struct packed {
    logic             valid;
    logic [CharW-1:0] char_code;
    logic             last_char;
  } emit_t;

endpackage

// ===== hw/rtl/iaf_dabble_step.sv =====
// one double-dabble step: add three to every bcd digit of five or more, then shift in a bit
// depends on iaf_pkg
module iaf_dabble_step (
  input  logic [iaf_pkg::DigitsW-1:0] bcd_i,
  input  logic                        bit_i,
  output logic [iaf_pkg::DigitsW-1:0] bcd_o
);
  import iaf_pkg::*;

  logic [DigitsW-1:0] adj;

  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      if (bcd_i[k*DigitW +: DigitW] >= DigitW'(5)) begin
        adj[k*DigitW +: DigitW] = bcd_i[k*DigitW +: DigitW] + DigitW'(3);
      end else begin
        adj[k*DigitW +: DigitW] = bcd_i[k*DigitW +: DigitW];
      end
    end
  end

  assign bcd_o = {adj[DigitsW-2:0], bit_i};

endmodule

// ===== hw/rtl/iaf_seq.sv =====
// sequencer: loads a word, runs the shared dabble step for decimal, drops leading zeros
// and hands out prefix and digit characters; depends on iaf_pkg and iaf_dabble_step
module iaf_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  iaf_pkg::cmd_e              cmd_i,
  input  logic [iaf_pkg::ValueW-1:0] value_i,
  output logic                       idle_o,
  input  logic                       slot_free_i,
  output iaf_pkg::emit_t             emit_o
);
  import iaf_pkg::*;

  state_e             state_q, state_d;
  cmd_e               mode_q, mode_d;
  logic               neg_q, neg_d;
  logic [ValueW-1:0]  bin_q, bin_d;
  logic [DigitsW-1:0] digits_q, digits_d;
  logic [NdigW-1:0]   ndig_q, ndig_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic [DigitsW-1:0] dabble_bcd;
  logic [DigitsW-1:0] octal_digits;
  logic [DigitW-1:0]  top_digit;
  logic               neg_in;

  iaf_dabble_step u_step (
    .bcd_i (digits_q),
    .bit_i (bin_q[ValueW-1]),
    .bcd_o (dabble_bcd)
  );

  // octal digits spread into four-bit slots, top slot holds the two leftover bits
  always_comb begin
    for (int k = 0; k < NumDigits - 1; k++) begin
      octal_digits[k*DigitW +: DigitW] = {1'b0, value_i[k*3 +: 3]};
    end
    octal_digits[DigitsW-1 -: DigitW] = {2'b00, value_i[ValueW-1 -: 2]};
  end

  assign top_digit = digits_q[DigitsW-1 -: DigitW];
  assign neg_in    = (cmd_i == CMD_SDEC) && value_i[ValueW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    neg_q    <= neg_d;
    bin_q    <= bin_d;
    digits_q <= digits_d;
    ndig_q   <= ndig_d;
    cnt_q    <= cnt_d;
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    neg_d    = neg_q;
    bin_d    = bin_q;
    digits_d = digits_q;
    ndig_d   = ndig_q;
    cnt_d    = cnt_q;
    idle_o   = 1'b0;
    emit_o   = '0;

    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          mode_d = cmd_i;
          neg_d  = neg_in;
          bin_d  = neg_in ? (~value_i + ValueW'(1)) : value_i;
          ndig_d = NdigW'(NumDigits);
          cnt_d  = '1;
          case (cmd_i)
            CMD_OCT: begin
              digits_d = octal_digits;
              state_d  = ST_SKIP;
            end
            CMD_HEX: begin
              digits_d = {{(DigitsW-ValueW){1'b0}}, value_i};
              state_d  = ST_SKIP;
            end
            default: begin
              digits_d = '0;
              state_d  = ST_CONV;
            end
          endcase
        end
      end

      ST_CONV: begin
        digits_d = dabble_bcd;
        bin_d    = {bin_q[ValueW-2:0], 1'b0};
        cnt_d    = cnt_q - CntW'(1);
        if (cnt_q == '0) begin
          state_d = ST_SKIP;
        end
      end

      ST_SKIP: begin
        if ((top_digit == '0) && (ndig_q > NdigW'(1))) begin
          digits_d = {digits_q[DigitsW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d   = ndig_q - NdigW'(1);
        end else begin
          case (mode_q)
            CMD_OCT, CMD_HEX: state_d = ST_ZERO;
            CMD_SDEC:         state_d = neg_q ? ST_MINUS : ST_DIGIT;
            default:          state_d = ST_DIGIT;
          endcase
        end
      end

      ST_MINUS: begin
        if (slot_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.char_code = AsciiMinus;
          state_d          = ST_DIGIT;
        end
      end

      ST_ZERO: begin
        if (slot_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.char_code = AsciiZero;
          state_d          = (mode_q == CMD_HEX) ? ST_X : ST_DIGIT;
        end
      end

      ST_X: begin
        if (slot_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.char_code = AsciiX;
          state_d          = ST_DIGIT;
        end
      end

      ST_DIGIT: begin
        if (slot_free_i) begin
          emit_o.valid     = 1'b1;
          emit_o.char_code = Glyphs[top_digit];
          emit_o.last_char = (ndig_q == NdigW'(1));
          digits_d         = {digits_q[DigitsW-DigitW-1:0], {DigitW{1'b0}}};
          ndig_d           = ndig_q - NdigW'(1);
          if (ndig_q == NdigW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// top level of the integer to ascii formatter: stream ports and the output register
// depends on iaf_pkg and iaf_seq
//
// Takes one 32-bit word per input transaction with a format on tuser (unsigned
// decimal, signed decimal, octal or hex) and sends its ascii text out as one
// character per output transaction, most significant digit first, with tlast on
// the final character. Hex digits are upper case and leading zeros are dropped.
// Signed mode sends '-' and then the magnitude (0x80000000 gives -2147483648);
// octal text starts with '0' and hex text with "0x"; a zero value still gives one
// '0' digit. One word passes through a load, then the shared double-dabble step
// over all input bits for the decimal formats, then a pass that drops leading
// zeros from the eleven digit slots and chooses the prefix, then the prefix
// characters and the remaining digits, which wait while the output side stalls.
// The work runs on a digit shift register with a single dabble unit. The input
// is taken only while the sequencer is idle, which it reaches as soon as the last
// character sits in the output register, so that register overlaps one word's
// tail with the next word's load.
module integer_to_ascii_formatter (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] char_code
  output logic        m_axis_tlast    // last_char
);
  import iaf_pkg::*;

  logic             idle;
  logic             slot_free;
  emit_t            emit;

  // output register, payload carries no reset
  logic             out_valid_q, out_valid_d;
  logic [CharW-1:0] out_char_q;
  logic             out_last_q;

  // slot is free when empty or when the waiting character leaves this cycle
  assign slot_free     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = idle;

  iaf_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (s_axis_tvalid),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .value_i     (s_axis_tdata),
    .idle_o      (idle),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (slot_free) begin
      out_valid_d = emit.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && emit.valid) begin
      out_char_q <= emit.char_code;
      out_last_q <= emit.last_char;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tlast  = out_last_q;

endmodule
